// ===== src/ventilation_fan_qualifier_top_defines.svh =====
// ----------------------------------------------------------------------------
// ventilation fan qualifier assertion macros
// shared concurrent assertion forms, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef VENTILATION_FAN_QUALIFIER_TOP_DEFINES_SVH
`define VENTILATION_FAN_QUALIFIER_TOP_DEFINES_SVH

// same-cycle implication
`define VFQ_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfq_pkg
// types and constants shared by the ventilation fan qualifier
// ----------------------------------------------------------------------------
package vfq_pkg;

  // field widths
  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned POL_W      = 10;
  localparam int unsigned DELTA_W    = 11;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  // register reset values
  localparam logic [DELTA_W-1:0] DELTA_RST  = DELTA_W'(8);
  localparam logic [POL_W-1:0]   MIDDLE_RST = POL_W'(400);
  localparam logic [POL_W-1:0]   HIGH_RST   = POL_W'(700);

  // item kind
  typedef enum logic {
    OP_TEMP = 1'b0,
    OP_POLL = 1'b1
  } vfq_op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FALLING_DELTA = 2'd0,
    CFG_MIDDLE_LEVEL  = 2'd1,
    CFG_HIGH_LEVEL    = 2'd2
  } vfq_cfg_e;

  // temperature sample request into the window unit
  typedef struct packed {
    logic                     take;
    logic signed [TEMP_W-1:0] sample;
  } vfq_req_t;

  // one result transaction
  typedef struct packed {
    logic fan_on;
    logic led_red;
    logic led_green;
    logic led_blue;
    logic temperature_falling;
    logic pollution_middle;
    logic pollution_high;
  } vfq_result_t;

endpackage

// ===== src/vfq_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfq_in_if
// input channel: one temperature or pollution sample per transaction
// ----------------------------------------------------------------------------
interface vfq_in_if;
  logic                                  valid;
  logic                                  ready;
  vfq_pkg::vfq_op_e                      op;
  logic signed [vfq_pkg::TEMP_W-1:0]     temperature;
  logic        [vfq_pkg::POL_W-1:0]      pollution;

  modport source (output valid, output op, output temperature, output pollution,
                  input ready);
  modport sink   (input valid, input op, input temperature, input pollution,
                  output ready);
endinterface
`default_nettype wire

// ===== src/vfq_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfq_out_if
// result channel: fan drive, lamp colour and current flags
// ----------------------------------------------------------------------------
interface vfq_out_if;
  logic valid;
  logic ready;
  logic fan_on;
  logic led_red;
  logic led_green;
  logic led_blue;
  logic temperature_falling;
  logic pollution_middle;
  logic pollution_high;

  modport source (output valid, output fan_on, output led_red, output led_green,
                  output led_blue, output temperature_falling,
                  output pollution_middle, output pollution_high, input ready);
  modport sink   (input valid, input fan_on, input led_red, input led_green,
                  input led_blue, input temperature_falling,
                  input pollution_middle, input pollution_high, output ready);
endinterface
`default_nettype wire

// ===== src/vfq_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfq_window
// sample ring in a synchronous memory, running sum and falling hysteresis
// ----------------------------------------------------------------------------
`include "ventilation_fan_qualifier_top_defines.svh"

module vfq_window #(
  parameter int unsigned WINDOW = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire vfq_pkg::vfq_req_t           req_i,
  input  wire                              commit_i,
  input  wire  [vfq_pkg::DELTA_W-1:0]      delta_i,
  output logic                             falling_nxt_o
);

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W = vfq_pkg::TEMP_W + IDX_W;
  localparam int unsigned CMP_W = SUM_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  // sample ring, undefined until written
  logic signed [vfq_pkg::TEMP_W-1:0] mem [WINDOW];

  // write side bookkeeping
  logic [IDX_W-1:0]                  idx_q;
  logic                              fresh_q;
  logic                              primed_q;
  logic signed [vfq_pkg::TEMP_W-1:0] prime_val_q;

  // stage one: sample plus the entry it evicts
  logic signed [vfq_pkg::TEMP_W-1:0] rd_q;
  logic signed [vfq_pkg::TEMP_W-1:0] s1_sample_q;
  logic [IDX_W-1:0]                  s1_idx_q;
  logic                              s1_fresh_q;
  logic                              s1_prime_q;
  logic                              s1_take_q;

  // running state
  logic signed [SUM_W-1:0]           sum_q, sum_d;
  logic                              falling_q, falling_d;

  logic signed [vfq_pkg::TEMP_W-1:0] old_val;
  logic signed [CMP_W-1:0]           win_c, s_ext, win_s, excess, limit;
  logic signed [SUM_W-1:0]           sum_base;

  // memory read on take, write back on commit
  always_ff @(posedge clk_i) begin
    if (req_i.take) begin
      rd_q        <= mem[idx_q];
      s1_sample_q <= req_i.sample;
      s1_idx_q    <= idx_q;
    end
    if (commit_i) begin
      mem[s1_idx_q] <= s1_sample_q;
    end
  end

  // priming value for entries not yet written since priming
  always_ff @(posedge clk_i) begin
    if (req_i.take && !primed_q) begin
      prime_val_q <= req_i.sample;
    end
  end

  // ring pointer and priming control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      fresh_q    <= 1'b1;
      primed_q   <= 1'b0;
      s1_fresh_q <= 1'b0;
      s1_prime_q <= 1'b0;
      s1_take_q  <= 1'b0;
    end else begin
      if (req_i.take) begin
        s1_fresh_q <= fresh_q;
        s1_prime_q <= !primed_q;
        s1_take_q  <= 1'b1;
        primed_q   <= 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_q   <= '0;
          fresh_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end else if (commit_i) begin
        s1_take_q <= 1'b0;
      end
    end
  end

  // exact mean test: sum - W*s against W*delta, or zero once falling
  always_comb begin
    old_val  = s1_fresh_q ? prime_val_q : rd_q;
    win_c    = CMP_W'(WINDOW);
    s_ext    = CMP_W'(s1_sample_q);
    win_s    = win_c * s_ext;
    sum_base = s1_prime_q ? SUM_W'(win_s) : sum_q;
    excess   = CMP_W'(sum_base) - win_s;
    limit    = falling_q ? '0 : win_c * $signed(CMP_W'(delta_i));
    falling_d = (excess > limit);
    sum_d    = sum_base + SUM_W'(s1_sample_q) - SUM_W'(old_val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      falling_q <= 1'b0;
    end else if (commit_i) begin
      sum_q     <= sum_d;
      falling_q <= falling_d;
    end
  end

  assign falling_nxt_o = commit_i ? falling_d : falling_q;

  `VFQ_ASSERT(a_commit_has_sample, commit_i, s1_take_q || req_i.take,
              "window commit without a pending sample")
  `VFQ_ASSERT_NEXT(a_primed_sticks, primed_q, primed_q,
                   "window lost its primed state")
  `VFQ_ASSERT(a_fresh_ends_on_wrap, $fell(fresh_q), idx_q == '0,
              "first pass ended away from ring start")

endmodule
`default_nettype wire

// ===== src/ventilation_fan_qualifier_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ventilation_fan_qualifier_top
// path: stage one, then output register; next ring read overlaps the last commit
// throughput: one transaction per cycle while the result port is not stalled
// reset: flags, sum and priming clear; the sample ring needs no clearing pass
// ----------------------------------------------------------------------------
`include "ventilation_fan_qualifier_top_defines.svh"

module ventilation_fan_qualifier_top #(
  parameter int unsigned WINDOW = 8
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  vfq_in_if.sink                              in_i,
  vfq_out_if.source                           out_o,
  input  wire                                 cfg_we_i,
  input  wire  [vfq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [vfq_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // configuration registers
  logic [vfq_pkg::DELTA_W-1:0] delta_q;
  logic [vfq_pkg::POL_W-1:0]   mid_lvl_q;
  logic [vfq_pkg::POL_W-1:0]   high_lvl_q;

  // stage one and output register
  logic                        s1_valid_q;
  vfq_pkg::vfq_op_e            s1_op_q;
  logic [vfq_pkg::POL_W-1:0]   s1_pol_q;
  logic                        out_valid_q;
  vfq_pkg::vfq_result_t        res_q, res_d;

  // pollution flags
  logic                        middle_q, high_q;
  logic                        middle_nxt, high_nxt, falling_nxt;

  logic                        advance, accept, commit, commit_temp;
  vfq_pkg::vfq_req_t           req;

  // handshake
  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || advance;
  assign accept      = in_i.valid && in_i.ready;
  assign commit      = s1_valid_q && advance;
  assign commit_temp = commit && (s1_op_q == vfq_pkg::OP_TEMP);

  assign req.take   = accept && (in_i.op == vfq_pkg::OP_TEMP);
  assign req.sample = in_i.temperature;

  vfq_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .commit_i      (commit_temp),
    .delta_i       (delta_q),
    .falling_nxt_o (falling_nxt)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q    <= vfq_pkg::DELTA_RST;
      mid_lvl_q  <= vfq_pkg::MIDDLE_RST;
      high_lvl_q <= vfq_pkg::HIGH_RST;
    end else if (cfg_we_i) begin
      case (vfq_pkg::vfq_cfg_e'(cfg_idx_i))
        vfq_pkg::CFG_FALLING_DELTA: delta_q    <= cfg_data_i[vfq_pkg::DELTA_W-1:0];
        vfq_pkg::CFG_MIDDLE_LEVEL:  mid_lvl_q  <= cfg_data_i[vfq_pkg::POL_W-1:0];
        vfq_pkg::CFG_HIGH_LEVEL:    high_lvl_q <= cfg_data_i[vfq_pkg::POL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= in_i.op;
      s1_pol_q <= in_i.pollution;
    end
  end

  // pollution thresholds and lamp priority
  always_comb begin
    if (s1_op_q == vfq_pkg::OP_POLL) begin
      middle_nxt = (s1_pol_q >= mid_lvl_q);
      high_nxt   = (s1_pol_q >= high_lvl_q);
    end else begin
      middle_nxt = middle_q;
      high_nxt   = high_q;
    end
    res_d                     = '0;
    res_d.fan_on              = falling_nxt || middle_nxt || high_nxt;
    res_d.temperature_falling = falling_nxt;
    res_d.pollution_middle    = middle_nxt;
    res_d.pollution_high      = high_nxt;
    if (falling_nxt && !middle_nxt && !high_nxt) begin
      res_d.led_blue = 1'b1;
    end else if (high_nxt) begin
      res_d.led_red = 1'b1;
    end else if (middle_nxt) begin
      res_d.led_red   = 1'b1;
      res_d.led_green = 1'b1;
    end else begin
      res_d.led_green = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_q <= res_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      middle_q    <= 1'b0;
      high_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (commit) begin
        s1_valid_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        middle_q    <= middle_nxt;
        high_q      <= high_nxt;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result port
  assign out_o.valid               = out_valid_q;
  assign out_o.fan_on              = res_q.fan_on;
  assign out_o.led_red             = res_q.led_red;
  assign out_o.led_green           = res_q.led_green;
  assign out_o.led_blue            = res_q.led_blue;
  assign out_o.temperature_falling = res_q.temperature_falling;
  assign out_o.pollution_middle    = res_q.pollution_middle;
  assign out_o.pollution_high      = res_q.pollution_high;

  `VFQ_ASSERT(a_blue_alone, out_valid_q && res_q.led_blue,
              !res_q.led_red && !res_q.led_green, "blue lamp shares a colour")
  `VFQ_ASSERT(a_fan_matches_flags, out_valid_q,
              res_q.fan_on == (res_q.temperature_falling || res_q.pollution_middle
                               || res_q.pollution_high), "fan drive disagrees with flags")
  `VFQ_ASSERT_NEXT(a_stalled_item_kept, s1_valid_q && !advance, s1_valid_q,
                   "stage one item dropped under stall")

endmodule
`default_nettype wire
